FILE: sv/lzsdec_pkg.sv
// ============================================================================
// lzsdec_pkg
// shared types and constants of the lzss byte stream decoder
// ============================================================================
`default_nettype none

package lzsdec_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_AW      = $clog2(WINDOW_SIZE);
    localparam int CNT_W       = WIN_AW + 1;
    localparam int RUN_MAX     = 18;
    localparam int RUN_W       = $clog2(RUN_MAX + 1);
    localparam int LEN_BIAS    = 3;
    localparam int DIST_BIAS   = 18;
    localparam int TOKENS      = 8;
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_AW      = $clog2(CMD_DEPTH);

    localparam logic [CNT_W-1:0]  WIN_FULL  = CNT_W'(WINDOW_SIZE);
    localparam logic [RUN_W-1:0]  RUN_LIMIT = RUN_W'(RUN_MAX);
    localparam logic [RUN_W-1:0]  LEN_ADD   = RUN_W'(LEN_BIAS);
    localparam logic [WIN_AW-1:0] DIST_SUB  = WIN_AW'(DIST_BIAS);
    localparam logic [3:0]        TOK_INIT  = 4'(TOKENS);

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_REF2  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SEL_LIT  = 2'd0,
        SEL_ZERO = 2'd1,
        SEL_RAM  = 2'd2
    } byte_sel_t;

    typedef struct packed {
        logic              lit;
        logic [7:0]        data;
        logic [WIN_AW-1:0] src;
        logic [WIN_AW-1:0] wp;
        logic [RUN_W-1:0]  zeros;
        logic [RUN_W-1:0]  count;
    } cmd_t;

endpackage

`default_nettype wire

FILE: sv/lzsdec_ram.sv
// ============================================================================
// lzsdec_ram
// generic single write port, single read port ram with registered read
// ============================================================================
`default_nettype none

module lzsdec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/lzsdec_front.sv
// ============================================================================
// lzsdec_front
// token parser: classifies compressed bytes and issues copy commands
// ============================================================================
`default_nettype none

module lzsdec_front import lzsdec_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] compressed_byte,
    input  wire logic       stream_start,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd_full,
    output logic            cmd_push,
    output cmd_t            cmd
);

    phase_t            phase_reg, phase_next, ph_eff;
    logic [7:0]        flag_reg, flag_next, fb_eff;
    logic [3:0]        tl_reg, tl_next, tl_eff, tl_dec;
    logic [7:0]        r1_reg, r1_next, r1_eff;
    logic [CNT_W-1:0]  pc_reg, pc_next, pc_eff, pc_sum;
    logic [WIN_AW-1:0] wp_reg, wp_next, wp_eff;
    logic              in_fire;

    logic [WIN_AW-1:0] offset, dist12, src;
    logic [RUN_W-1:0]  length, zeros;
    logic [CNT_W-1:0]  dist13, zeros_full;

    assign in_ready = !cmd_full;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG;
            flag_reg  <= '0;
            tl_reg    <= '0;
            r1_reg    <= '0;
            pc_reg    <= '0;
            wp_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            tl_reg    <= tl_next;
            r1_reg    <= r1_next;
            pc_reg    <= pc_next;
            wp_reg    <= wp_next;
        end
    end

    // parser state as seen by this byte
    always_comb
    begin
        ph_eff = phase_reg;
        fb_eff = flag_reg;
        tl_eff = tl_reg;
        r1_eff = r1_reg;
        pc_eff = pc_reg;
        wp_eff = wp_reg;
        if (stream_start)
        begin
            ph_eff = PH_FLAG;
            fb_eff = '0;
            tl_eff = '0;
            r1_eff = '0;
            pc_eff = '0;
            wp_eff = '0;
        end
        if (ph_eff == PH_TOKEN && tl_eff == '0)
        begin
            ph_eff = PH_FLAG;
        end
    end

    // reference geometry
    assign offset     = {compressed_byte[7:4], r1_eff};
    assign length     = RUN_W'(compressed_byte[3:0]) + LEN_ADD;
    assign dist12     = wp_eff - DIST_SUB - offset;
    assign dist13     = (dist12 == '0) ? WIN_FULL : {1'b0, dist12};
    assign zeros_full = (dist13 > pc_eff) ? (dist13 - pc_eff) : '0;
    assign zeros      = (zeros_full > CNT_W'(RUN_LIMIT)) ? RUN_LIMIT : zeros_full[RUN_W-1:0];
    assign src        = wp_eff - dist12;
    assign tl_dec     = tl_eff - 4'd1;

    always_comb
    begin
        phase_next = ph_eff;
        flag_next  = fb_eff;
        tl_next    = tl_eff;
        r1_next    = r1_eff;
        pc_next    = pc_eff;
        wp_next    = wp_eff;
        pc_sum     = pc_eff + CNT_W'(length);
        cmd_push   = 1'b0;
        cmd        = '0;
        cmd.wp     = wp_eff;
        case (ph_eff)
            PH_TOKEN:
            begin
                if (fb_eff[0])
                begin
                    cmd_push   = in_fire;
                    cmd.lit    = 1'b1;
                    cmd.data   = compressed_byte;
                    cmd.count  = RUN_W'(1);
                    wp_next    = wp_eff + WIN_AW'(1);
                    pc_next    = (pc_eff == WIN_FULL) ? pc_eff : pc_eff + CNT_W'(1);
                    flag_next  = fb_eff >> 1;
                    tl_next    = tl_dec;
                    phase_next = (tl_dec == '0) ? PH_FLAG : PH_TOKEN;
                end
                else
                begin
                    r1_next    = compressed_byte;
                    phase_next = PH_REF2;
                end
            end
            PH_REF2:
            begin
                cmd_push   = in_fire;
                cmd.src    = src;
                cmd.zeros  = zeros;
                cmd.count  = length;
                wp_next    = wp_eff + WIN_AW'(length);
                pc_next    = (pc_sum > WIN_FULL) ? WIN_FULL : pc_sum;
                flag_next  = fb_eff >> 1;
                tl_next    = tl_dec;
                phase_next = (tl_dec == '0) ? PH_FLAG : PH_TOKEN;
            end
            default:
            begin
                flag_next  = compressed_byte;
                tl_next    = TOK_INIT;
                phase_next = PH_TOKEN;
            end
        endcase
    end

    a_token_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TOKEN |-> tl_reg != '0)
        else $error("token phase with no tokens left");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= WIN_FULL)
        else $error("produced count beyond window size");

endmodule

`default_nettype wire

FILE: sv/lzsdec_cmd_fifo.sv
// ============================================================================
// lzsdec_cmd_fifo
// short command queue between parser and copy engine
// ============================================================================
`default_nettype none

module lzsdec_cmd_fifo import lzsdec_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output logic      not_empty
);

    cmd_t              entry_reg [CMD_DEPTH];
    logic [CMD_AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CMD_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (CMD_AW+1)'(CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[head_reg];

    always_comb
    begin
        head_next  = pop  ? head_reg + CMD_AW'(1) : head_reg;
        tail_next  = push ? tail_reg + CMD_AW'(1) : tail_reg;
        count_next = count_reg + (CMD_AW+1)'(push) - (CMD_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

endmodule

`default_nettype wire

FILE: sv/lzsdec_back.sv
// ============================================================================
// lzsdec_back
// copy engine: expands commands into bytes through the history window
// ============================================================================
`default_nettype none

module lzsdec_back import lzsdec_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cmd_t  head_cmd,
    input  wire logic  cmd_valid,
    output logic       cmd_pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       out_valid,
    input  wire logic  out_ready
);

    // current command
    logic              cur_valid_reg;
    cmd_t              cur_reg;

    // byte stage waiting for ram data
    logic              d_valid_reg;
    byte_sel_t         d_sel_reg, issue_sel;
    logic [7:0]        d_data_reg;
    logic [WIN_AW-1:0] d_wp_reg;
    logic              d_last_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;

    logic              d_fire, issue, issue_last;
    logic [7:0]        ram_rdata, emit_byte;

    assign d_fire     = d_valid_reg && (!out_valid_reg || out_ready);
    assign issue      = cur_valid_reg && (!d_valid_reg || d_fire);
    assign issue_last = issue && (cur_reg.count == RUN_W'(1));
    assign cmd_pop    = cmd_valid && (!cur_valid_reg || issue_last);

    always_comb
    begin
        if (cur_reg.lit)
        begin
            issue_sel = SEL_LIT;
        end
        else if (cur_reg.zeros != '0)
        begin
            issue_sel = SEL_ZERO;
        end
        else
        begin
            issue_sel = SEL_RAM;
        end
    end

    always_comb
    begin
        case (d_sel_reg)
            SEL_LIT:  emit_byte = d_data_reg;
            SEL_ZERO: emit_byte = '0;
            SEL_RAM:  emit_byte = fwd_hit_reg ? fwd_data_reg : ram_rdata;
            default:  emit_byte = '0;
        endcase
    end

    lzsdec_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (d_fire),
        .waddr (d_wp_reg),
        .wdata (emit_byte),
        .re    (issue && issue_sel == SEL_RAM),
        .raddr (cur_reg.src),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (issue_last)
            begin
                cur_valid_reg <= 1'b0;
            end
            if (issue)
            begin
                d_valid_reg <= 1'b1;
            end
            else if (d_fire)
            begin
                d_valid_reg <= 1'b0;
            end
            if (d_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= head_cmd;
        end
        else if (issue)
        begin
            cur_reg.src   <= cur_reg.src + WIN_AW'(1);
            cur_reg.wp    <= cur_reg.wp + WIN_AW'(1);
            cur_reg.count <= cur_reg.count - RUN_W'(1);
            if (cur_reg.zeros != '0)
            begin
                cur_reg.zeros <= cur_reg.zeros - RUN_W'(1);
            end
        end
        if (issue)
        begin
            d_sel_reg    <= issue_sel;
            d_data_reg   <= cur_reg.data;
            d_wp_reg     <= cur_reg.wp;
            d_last_reg   <= issue_last;
            // byte written this cycle is the one being read
            fwd_hit_reg  <= d_fire && (d_wp_reg == cur_reg.src);
            fwd_data_reg <= emit_byte;
        end
        if (d_fire)
        begin
            out_byte_reg <= emit_byte;
            run_last_reg <= d_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

    a_cur_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_reg.count != '0)
        else $error("active command with no bytes left");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && out_valid_reg && !out_ready |=> d_valid_reg)
        else $error("byte stage dropped while output stalled");

endmodule

`default_nettype wire

FILE: sv/lzss_byte_stream_decoder.sv
// ============================================================================
// lzss_byte_stream_decoder
// lzss decompressor with a 4096 byte history window
// ============================================================================
// input channel: one compressed byte per item (compressed_byte, stream_start)
// on in_valid/in_ready; stream_start on the first byte of a stream clears
// the parser, the produced count and the window pointer.
// output channel: one decompressed byte per item (out_byte, run_last) on
// out_valid/out_ready; run_last marks the last byte caused by one input.
// the parser takes one input byte per cycle while its four entry command
// queue has room; flag bytes and first reference bytes produce nothing.
// the copy engine emits one byte per cycle while the receiver takes them: a
// literal gives one byte, a reference 3 to 18 bytes through the window ram.
// an accepted byte's command passes the queue, the current command register,
// the byte stage and the output register on its way out.
// when the receiver stalls the output register holds, the engine stops and
// the queue fills, after which in_ready drops.
// reset empties queue and pipeline and puts the parser at a flag byte; the
// window ram is not cleared, bytes before the stream start read as zero.
// ============================================================================
`default_nettype none

module lzss_byte_stream_decoder import lzsdec_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] compressed_byte,
    input  wire logic       stream_start,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            out_valid,
    input  wire logic       out_ready
);

    cmd_t push_cmd, head_cmd;
    logic cmd_push, cmd_full, cmd_pop, cmd_valid;

    lzsdec_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .compressed_byte (compressed_byte),
        .stream_start    (stream_start),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd_full        (cmd_full),
        .cmd_push        (cmd_push),
        .cmd             (push_cmd)
    );

    lzsdec_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .head_cmd  (head_cmd),
        .not_empty (cmd_valid)
    );

    lzsdec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ============================================================================
// tb_top
// self-checking testbench of the lzss byte stream decoder
// ============================================================================
// compressed bytes go in on the input channel and every decoded byte that
// comes out is checked against a predictor that decodes the same stream:
// flag bytes, literals, references with overlap, sources before the stream
// start, zero distance and restarts in the middle of a token. random streams
// follow, the sender and the receiver idling at random, then not at all.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lzsdec_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } decoded_byte_t;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic [7:0] compressed_byte = '0;
    logic       stream_start    = 1'b0;
    logic       in_valid        = 1'b0;
    logic       in_ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_valid;
    logic       out_ready       = 1'b0;

    decoded_byte_t expected_bytes[$];
    int            mismatches    = 0;
    int            cycles        = 0;
    int            sent_items    = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    phase_t      dec_phase;
    logic [7:0]  dec_flags;
    logic [3:0]  dec_tokens;
    logic [7:0]  dec_ref_lo;
    logic [12:0] dec_count;
    logic [11:0] dec_wptr;
    logic [7:0]  history [WINDOW_SIZE];

    always #5 clk = ~clk;

    lzss_byte_stream_decoder i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .compressed_byte (compressed_byte),
        .stream_start    (stream_start),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .out_byte        (out_byte),
        .run_last        (run_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready)
    );

    function automatic void clear_parser();
        dec_phase  = PH_FLAG;
        dec_flags  = '0;
        dec_tokens = '0;
        dec_ref_lo = '0;
        dec_count  = '0;
        dec_wptr   = '0;
    endfunction

    function automatic void store_byte(input logic [7:0] v);
        history[dec_wptr] = v;
        dec_wptr = dec_wptr + 12'd1;
        if (dec_count < WIN_FULL)
            dec_count = dec_count + 13'd1;
        expected_bytes.push_back('{value: v, last: 1'b0});
    endfunction

    function automatic void next_token();
        dec_flags = dec_flags >> 1;
        if (dec_tokens != 0)
            dec_tokens = dec_tokens - 4'd1;
        dec_phase = (dec_tokens == 0) ? PH_FLAG : PH_TOKEN;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic start);
        logic [11:0]   offset;
        logic [11:0]   back;
        logic [12:0]   distance;
        logic [12:0]   zeros;
        logic [11:0]   src;
        int            length;
        int            queued;
        decoded_byte_t tail;
        queued = expected_bytes.size();
        if (start)
            clear_parser();
        if (dec_phase == PH_TOKEN && dec_tokens == 0)
            dec_phase = PH_FLAG;
        case (dec_phase)
            PH_TOKEN:
            begin
                if (dec_flags[0])
                begin
                    store_byte(b);
                    next_token();
                end
                else
                begin
                    dec_ref_lo = b;
                    dec_phase  = PH_REF2;
                end
            end
            PH_REF2:
            begin
                offset   = {b[7:4], dec_ref_lo};
                length   = int'(b[3:0]) + LEN_BIAS;
                back     = dec_wptr - DIST_SUB - offset;
                distance = (back == '0) ? 13'(WINDOW_SIZE) : {1'b0, back};
                zeros    = (distance > dec_count) ? distance - dec_count : '0;
                src      = dec_wptr - distance[11:0];
                for (int i = 0; i < length; i++)
                begin
                    if (zeros != 0)
                    begin
                        store_byte(8'h00);
                        zeros = zeros - 13'd1;
                    end
                    else
                        store_byte(history[src]);
                    src = src + 12'd1;
                end
                next_token();
            end
            default:
            begin
                dec_flags  = b;
                dec_tokens = TOK_INIT;
                dec_phase  = PH_TOKEN;
            end
        endcase
        if (expected_bytes.size() > queued)
        begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start);
        in_valid        <= 1'b1;
        compressed_byte <= b;
        stream_start    <= start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b, start);
        sent_items++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // distance counts back from the next output byte, 4096 encodes as zero
    task automatic send_ref(input int distance, input int length);
        logic [11:0] offset;
        offset = dec_wptr - DIST_SUB - 12'(distance);
        send_byte(offset[7:0], 1'b0);
        send_byte({offset[11:8], 4'(length - LEN_BIAS)}, 1'b0);
    endtask

    function automatic int reach_back();
        return (dec_count == 0) ? 1 : ((dec_count > 4095) ? 4095 : int'(dec_count));
    endfunction

    task automatic test_literals();
        logic [7:0] lits [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
        send_byte(8'hFF, 1'b1);
        foreach (lits[i])
            send_byte(lits[i], 1'b0);
    endtask

    task automatic test_references();
        send_byte(8'hE0, 1'b0);
        // overlapping copy of the last byte
        send_ref(1, RUN_MAX);
        // source partly before the stream start
        send_ref(int'(dec_count) + 2, 5);
        // zero distance
        send_ref(WINDOW_SIZE, LEN_BIAS);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
    endtask

    task automatic test_restart();
        send_byte(8'h00, 1'b1);
        send_byte(8'h40, 1'b0);
        // restart between the two bytes of a reference
        send_byte(8'h01, 1'b1);
        send_byte(8'hC3, 1'b0);
    endtask

    task automatic test_random(input int count);
        int         stop;
        logic [7:0] flags;
        stop = sent_items + count;
        while (sent_items < stop)
        begin
            flags = 8'($urandom);
            send_byte(flags, $urandom_range(9) == 0);
            for (int t = 0; t < 8 && sent_items < stop; t++)
            begin
                if (flags[t])
                    send_byte(8'($urandom), $urandom_range(49) == 0);
                else if ($urandom_range(4) == 0)
                begin
                    send_byte(8'($urandom), 1'b0);
                    send_byte(8'($urandom), $urandom_range(49) == 0);
                end
                else
                    send_ref($urandom_range(reach_back() + 4, 1),
                             $urandom_range(RUN_MAX, LEN_BIAS));
            end
        end
    endtask

    always @(posedge clk)
    begin
        decoded_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output item: out_byte %h run_last %b",
                             out_byte, run_last);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value || run_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"output mismatch: out_byte exp %h got %h, ",
                                  "run_last exp %b got %b"},
                                 want.value, out_byte, want.last, run_last);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 65;
        test_literals();
        test_references();
        test_restart();
        test_random(110);

        send_idle_pct = 65;
        recv_idle_pct = 19;
        test_random(110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(110);

        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
